/* hdl/atrx_pkg.sv */
`timescale 1ns / 1ps

package atrx_pkg;

    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_BINARY = 2'd1,
        KIND_CHAR   = 2'd2,
        KIND_MARKER = 2'd3
    } kind_t;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_ARM  = 1'b1;

    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] MARKER_BYTE = 8'h01;

    typedef struct packed {
        logic        operation;
        logic [7:0]  rx_byte;
        logic [15:0] binary_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] position;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic  load;
        logic  arm;
        logic  bin_step;
        logic  emit;
        kind_t emit_kind;
        logic  store;
        logic  backsp;
        logic  line_clear;
        logic  ovf_set;
        logic  idx_clear;
        logic  idx_inc;
        logic  mem_rd;
    } cmd_t;

    typedef struct packed {
        logic is_arm;
        logic is_cr;
        logic is_lf;
        logic is_bs;
        logic bin_pending;
        logic echo_en;
        logic overflow;
        logic line_empty;
        logic line_full;
        logic idx_last;
        logic out_free;
    } stat_t;

endpackage

/* hdl/atrx_ctrl.sv */
`timescale 1ns / 1ps

module atrx_ctrl
    import atrx_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LINE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.emit_kind = KIND_ECHO;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.is_arm) begin
                    cmd.arm    = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.bin_pending) begin
                    if (stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_BINARY;
                        cmd.bin_step  = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (stat.echo_en) begin
                    if (stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_ECHO;
                        state_next    = ST_LINE;
                    end
                end else begin
                    state_next = ST_LINE;
                end
            end
            ST_LINE: begin
                if (stat.is_cr) begin
                    if (stat.overflow) begin
                        if (stat.out_free) begin
                            cmd.emit       = 1'b1;
                            cmd.emit_kind  = KIND_MARKER;
                            cmd.line_clear = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end else if (stat.line_empty) begin
                        cmd.line_clear = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_READ;
                    end
                end else if (stat.is_lf) begin
                    state_next = ST_IDLE;
                end else if (stat.is_bs) begin
                    cmd.backsp = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    if (stat.line_full) begin
                        cmd.ovf_set = 1'b1;
                    end else begin
                        cmd.store = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_CHAR;
                    if (stat.idx_last) begin
                        cmd.line_clear = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/atrx_dp.sv */
`timescale 1ns / 1ps

module atrx_dp
    import atrx_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output logic [31:0] cfg_rdata,
    input  cmd_t        cmd,
    output stat_t       stat
);

    localparam int LEN_W = $clog2(LINE_MAX);

    in_item_t        item_reg;
    logic [7:0]      mem [LINE_MAX];
    logic [7:0]      rdata_reg;
    logic [LEN_W-1:0] line_len_reg;
    logic [LEN_W-1:0] idx_reg;
    logic            ovf_reg;
    logic [15:0]     needed_reg;
    logic [15:0]     received_reg;
    logic            echo_reg;
    logic            m_valid_reg;
    out_item_t       m_data_reg;
    out_item_t       m_data_next;
    logic            bin_last;
    logic            out_free;

    assign bin_last  = ({1'b0, received_reg} + 17'd1) == {1'b0, needed_reg};
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_rdata = {31'd0, echo_reg};

    always_comb begin
        stat.is_arm      = (item_reg.operation == OP_ARM);
        stat.is_cr       = (item_reg.rx_byte == CH_CR);
        stat.is_lf       = (item_reg.rx_byte == CH_LF);
        stat.is_bs       = (item_reg.rx_byte == CH_BS) || (item_reg.rx_byte == CH_DEL);
        stat.bin_pending = (received_reg < needed_reg);
        stat.echo_en     = echo_reg;
        stat.overflow    = ovf_reg;
        stat.line_empty  = (line_len_reg == '0);
        stat.line_full   = (line_len_reg == LEN_W'(LINE_MAX - 1));
        stat.idx_last    = (idx_reg == line_len_reg - LEN_W'(1));
        stat.out_free    = out_free;
    end

    always_comb begin
        m_data_next = '0;
        case (cmd.emit_kind)
            KIND_ECHO: begin
                m_data_next.kind      = KIND_ECHO;
                m_data_next.data_byte = item_reg.rx_byte;
            end
            KIND_BINARY: begin
                m_data_next.kind      = KIND_BINARY;
                m_data_next.data_byte = item_reg.rx_byte;
                m_data_next.position  = received_reg;
                m_data_next.last      = bin_last;
            end
            KIND_CHAR: begin
                m_data_next.kind      = KIND_CHAR;
                m_data_next.data_byte = rdata_reg;
                m_data_next.position  = 16'(idx_reg);
                m_data_next.last      = stat.idx_last;
            end
            KIND_MARKER: begin
                m_data_next.kind      = KIND_MARKER;
                m_data_next.data_byte = MARKER_BYTE;
                m_data_next.last      = 1'b1;
            end
            default: begin
                m_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.store) begin
            mem[line_len_reg] <= item_reg.rx_byte;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[idx_reg];
        end
        if (cmd.emit) begin
            m_data_reg <= m_data_next;
        end
        if (cmd.idx_clear) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg <= '0;
            ovf_reg      <= 1'b0;
            needed_reg   <= '0;
            received_reg <= '0;
            echo_reg     <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                echo_reg <= cfg_wdata;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.arm) begin
                needed_reg   <= item_reg.binary_count;
                received_reg <= '0;
            end else if (cmd.bin_step) begin
                if (bin_last) begin
                    needed_reg   <= '0;
                    received_reg <= '0;
                end else begin
                    received_reg <= received_reg + 16'd1;
                end
            end
            if (cmd.line_clear) begin
                line_len_reg <= '0;
                ovf_reg      <= 1'b0;
            end else if (cmd.store) begin
                line_len_reg <= line_len_reg + LEN_W'(1);
            end else if (cmd.backsp && line_len_reg != '0) begin
                line_len_reg <= line_len_reg - LEN_W'(1);
            end
            if (cmd.ovf_set) begin
                ovf_reg <= 1'b1;
            end
        end
    end

endmodule

/* hdl/at_rx_line_assembler.sv */
`timescale 1ns / 1ps
// Receive-side line assembler for a UART command interface.
// The s_ channel takes one beat per received byte, or a command that arms a
// binary entry of a given length (a length of zero cancels the entry).
// The m_ channel delivers result beats: echoed bytes, indexed binary data
// bytes, the characters of a completed line, or a single overflow marker.
// The echo_enable register sits at address 0 of the APB port; the user must
// write it only while the block is idle, as the block does not enforce this.
// A plain byte occupies the block through acceptance, decode with echo, and
// the line update. An arm command or a binary data byte ends after decode.
// A carriage return on a stored line reads its characters out in turn,
// since each character needs one line store read and one output load.
// The output register holds a finished beat while the next one is prepared,
// and a stalled receiver holds the controller at its next output step.
// After reset the line is empty, no binary entry is pending and echo is on.

module at_rx_line_assembler
    import atrx_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ADDR_ECHO = 2'd0;

    cmd_t  cmd;
    stat_t stat;
    logic  cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == ADDR_ECHO);

    atrx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    atrx_dp #(
        .LINE_MAX (LINE_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[0]),
        .cfg_rdata (prdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* test/at_rx_line_assembler_checker.sv */
`timescale 1ns / 1ps

module at_rx_line_assembler_checker
    import atrx_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          awaited,
    output int          beats_in,
    output int          beats_out
);

    localparam logic [1:0] ADDR_ECHO = 2'd0;
    localparam int STORE_DEPTH = 64;
    localparam int LINE_CAP = (LINE_MAX - 1 > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : LINE_MAX - 1;

    logic        echo_on;
    logic [7:0]  line_buf [STORE_DEPTH];
    logic [6:0]  line_len;
    logic        line_ovf;
    logic [15:0] bin_total;
    logic [15:0] bin_got;
    out_item_t   pending_beats [$];
    int          err_cnt;
    int          in_cnt;
    int          out_cnt;

    function automatic out_item_t make_beat(kind_t k, logic [7:0] b, logic [15:0] pos,
                                            logic fin);
        out_item_t beat;
        beat.kind      = k;
        beat.data_byte = b;
        beat.position  = pos;
        beat.last      = fin;
        return beat;
    endfunction

    task automatic assemble_rx_beat(input in_item_t it);
        logic fin;
        if (it.operation == OP_ARM) begin
            bin_total = it.binary_count;
            bin_got   = '0;
            return;
        end
        if (bin_got < bin_total) begin
            fin = ({1'b0, bin_got} + 17'd1) == {1'b0, bin_total};
            pending_beats.push_back(make_beat(KIND_BINARY, it.rx_byte, bin_got, fin));
            if (fin) begin
                bin_total = '0;
                bin_got   = '0;
            end else begin
                bin_got = bin_got + 16'd1;
            end
            return;
        end
        if (echo_on) begin
            pending_beats.push_back(make_beat(KIND_ECHO, it.rx_byte, 16'd0, 1'b0));
        end
        if (it.rx_byte == CH_CR) begin
            if (line_ovf) begin
                pending_beats.push_back(make_beat(KIND_MARKER, MARKER_BYTE, 16'd0, 1'b1));
            end else begin
                for (int i = 0; i < line_len; i++) begin
                    pending_beats.push_back(make_beat(KIND_CHAR, line_buf[i], 16'(i),
                                                      (i + 1) == line_len));
                end
            end
            line_len = '0;
            line_ovf = 1'b0;
        end else if (it.rx_byte == CH_LF) begin
        end else if (it.rx_byte == CH_BS || it.rx_byte == CH_DEL) begin
            if (line_len != 0) begin
                line_len = line_len - 7'd1;
            end
        end else if (line_len < LINE_CAP) begin
            line_buf[line_len[5:0]] = it.rx_byte;
            line_len = line_len + 7'd1;
        end else begin
            line_ovf = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            echo_on   = 1'b1;
            line_len  = '0;
            line_ovf  = 1'b0;
            bin_total = '0;
            bin_got   = '0;
            pending_beats.delete();
            err_cnt   = 0;
            in_cnt    = 0;
            out_cnt   = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_ECHO) begin
                echo_on = pwdata[0];
            end
            if (s_valid && s_ready) begin
                in_cnt++;
                assemble_rx_beat(s_data);
            end
            if (m_valid && m_ready) begin
                out_cnt++;
                if (pending_beats.size() == 0) begin
                    $error("extra result beat: kind %0d, data_byte %0h, position %0d, last %0b",
                           m_data.kind, m_data.data_byte, m_data.position, m_data.last);
                    err_cnt++;
                end else begin
                    want = pending_beats.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_data.kind));
                    check_field("data_byte", 16'(want.data_byte), 16'(m_data.data_byte));
                    check_field("position", want.position, m_data.position);
                    check_field("last", 16'(want.last), 16'(m_data.last));
                end
            end
        end
        mismatches <= err_cnt;
        awaited    <= pending_beats.size();
        beats_in   <= in_cnt;
        beats_out  <= out_cnt;
    end

endmodule

/* test/at_rx_line_assembler_tb.sv */
`timescale 1ns / 1ps

module at_rx_line_assembler_tb
    import atrx_pkg::*;
;

    localparam int LINE_MAX = 64;
    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 9;
    localparam logic [1:0] ADDR_ECHO = 2'd0;
    localparam int DRAIN_TAIL = 3 + 2 * LINE_MAX + 16;
    localparam int DRAIN_BOUND = 400000;
    localparam int unsigned RUN_LIMIT_NS = 50_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = ADDR_ECHO;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int awaited;
    int beats_in;
    int beats_out;
    int sent = 0;
    int echo_writes = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    at_rx_line_assembler #(
        .LINE_MAX(LINE_MAX)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    at_rx_line_assembler_checker #(
        .LINE_MAX(LINE_MAX)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .awaited    (awaited),
        .beats_in   (beats_in),
        .beats_out  (beats_out)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left <= stall_len();
            end
        end
    end

    function automatic in_item_t rx_item(input logic [7:0] b);
        in_item_t it;
        it.operation    = OP_BYTE;
        it.rx_byte      = b;
        it.binary_count = 16'($urandom);
        return it;
    endfunction

    function automatic in_item_t arm_item(input logic [15:0] n);
        in_item_t it;
        it.operation    = OP_ARM;
        it.rx_byte      = 8'($urandom);
        it.binary_count = n;
        return it;
    endfunction

    task automatic send_beat(input in_item_t it);
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sent++;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : stall_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain(input int tail);
        s_valid <= 1'b0;
        @(posedge aclk);
        for (int w = 0; w < DRAIN_BOUND && awaited != 0; w++) begin
            @(posedge aclk);
        end
        repeat (tail) @(posedge aclk);
    endtask

    task automatic set_echo(input logic on);
        drain(DRAIN_TAIL);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ECHO;
        pwdata  <= {31'($urandom), on};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        echo_writes++;
    endtask

    task automatic line_seq(input int len, input bit clean);
        int r;
        logic [7:0] ch;
        for (int k = 0; k < len; k++) begin
            r = clean ? 99 : $urandom_range(0, 99);
            if (r < 5) begin
                ch = r[0] ? CH_BS : CH_DEL;
            end else if (r < 9) begin
                ch = CH_LF;
            end else if (r < 12) begin
                ch = 8'($urandom);
            end else if (r < 25) begin
                ch = 8'($urandom_range(128, 255));
            end else begin
                ch = 8'($urandom_range(32, 126));
            end
            send_beat(rx_item(ch));
        end
        send_beat(rx_item(CH_CR));
    endtask

    task automatic binary_seq();
        int n;
        int fed;
        int pick;
        logic [7:0] ch;
        n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        send_beat(arm_item(16'(n)));
        fed = ($urandom_range(0, 99) < 85) ? n : $urandom_range(0, n - 1);
        for (int k = 0; k < fed; k++) begin
            pick = $urandom_range(0, 11);
            case (pick)
                0: ch = CH_CR;
                1: ch = CH_LF;
                2: ch = CH_BS;
                3: ch = CH_DEL;
                default: ch = 8'($urandom);
            endcase
            send_beat(rx_item(ch));
        end
        if (fed < n) begin
            send_beat(arm_item($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 4))));
        end
    endtask

    task automatic noise_seq();
        if ($urandom_range(0, 1) == 1) begin
            send_beat(rx_item(8'($urandom)));
        end else begin
            send_beat(arm_item(16'($urandom)));
            repeat ($urandom_range(0, 3)) send_beat(rx_item(8'($urandom)));
            send_beat(arm_item(16'd0));
        end
    endtask

    task automatic random_phase(input int n_items, input bit with_capacity);
        int stop_at;
        int pick;
        stop_at = sent + n_items;
        if (with_capacity) begin
            line_seq(LINE_MAX - 1, 1'b1);
            line_seq(LINE_MAX + 3, 1'b1);
        end
        while (sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                line_seq(($urandom_range(0, 99) < 8) ? $urandom_range(60, 70)
                                                     : $urandom_range(0, 12), 1'b0);
            end else if (pick < 80) begin
                binary_seq();
            end else begin
                noise_seq();
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(rx_item(CH_CR));
        send_beat(rx_item(CH_BS));
        send_beat(rx_item(8'h41));
        send_beat(rx_item(8'h00));
        send_beat(rx_item(8'hFF));
        send_beat(rx_item(8'h80));
        send_beat(rx_item(CH_DEL));
        send_beat(rx_item(CH_LF));
        send_beat(rx_item(CH_CR));
        send_beat(arm_item(16'd3));
        send_beat(rx_item(CH_CR));
        send_beat(rx_item(CH_LF));
        send_beat(rx_item(CH_BS));
        send_beat(arm_item(16'd5));
        send_beat(rx_item(8'h55));
        send_beat(arm_item(16'd2));
        send_beat(rx_item(8'hAA));
        send_beat(rx_item(CH_DEL));
        send_beat(arm_item(16'd4));
        send_beat(arm_item(16'd0));
        send_beat(rx_item(8'h42));
        send_beat(rx_item(CH_CR));
        send_beat(arm_item(16'hFFFF));
        send_beat(rx_item(8'h5A));
        send_beat(arm_item(16'd0));

        set_echo(1'b0);
        send_beat(rx_item(8'h71));
        send_beat(rx_item(CH_LF));
        send_beat(rx_item(CH_CR));

        set_echo(1'b1);
        random_phase(130, 1'b1);
        set_echo(1'b0);
        quiet <= 1'b1;
        random_phase(30, 1'b0);
        quiet <= 1'b0;
        set_echo(1'b1);
        random_phase(30, 1'b0);
        set_echo(1'b0);
        random_phase(30, 1'b0);

        drain(DRAIN_TAIL);
        $display("Checked %0d input beats and %0d result beats across %0d echo settings.",
                 beats_in, beats_out, echo_writes + 1);
        if (mismatches == 0 && awaited == 0) begin
            $display("at_rx_line_assembler_tb OK");
        end else begin
            if (awaited != 0) begin
                $error("%0d expected result beats never arrived", awaited);
            end
            $display("at_rx_line_assembler_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("at_rx_line_assembler_tb NOT OK");
        $finish;
    end

endmodule

/* at_rx_line_assembler.f */
hdl/atrx_pkg.sv
hdl/atrx_ctrl.sv
hdl/atrx_dp.sv
hdl/at_rx_line_assembler.sv
test/at_rx_line_assembler_checker.sv
test/at_rx_line_assembler_tb.sv
